FILE: src/psc_pkg.sv
`default_nettype none
package psc_pkg;

    localparam logic [63:0] MAGIC_RESET = 64'hBADC0FFEE0DDF00D;
    localparam logic [15:0] MIN_HEADER_LEN = 16'd16;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        V_IN_ORDER     = 3'd0,
        V_GAP          = 3'd1,
        V_OUT_OF_ORDER = 3'd2,
        V_BAD_MAGIC    = 3'd3,
        V_TOO_SHORT    = 3'd4
    } t_verdict;

    typedef enum logic [1:0] {
        C_VALID     = 2'd0,
        C_BAD_MAGIC = 2'd1,
        C_SHORT     = 2'd2
    } t_class;

    typedef struct packed {
        t_class      cls;
        logic [63:0] seq;
    } t_qentry;

    typedef struct packed {
        logic valid;
        logic ready;
    } t_hs;

endpackage
`default_nettype wire

FILE: src/packet_sequence_checker_core.sv
`default_nettype none
// Checks received packet headers for length, magic word and sequence order, one beat per
// clock cycle sustained: an accepted header is written into the queue and then popped into the
// result registers, and the length and magic compare in the front, the two-entry queue and the
// sequence compare and counter update in the back let a new header follow every
// cycle while the output register is drained. All counters are 64 bits and wrap; the counter
// outputs are the running totals including the packet of the current result beat. The magic
// register resets to 0xBADC0FFEE0DDF00D and should be written only while no header is in flight.
module packet_sequence_checker_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [15:0] i_packet_length,
    input  wire logic [63:0] i_magic_word,
    input  wire logic [63:0] i_sequence_number,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_verdict,
    output logic [63:0]      o_gap_amount,
    output logic [63:0]      o_received_count,
    output logic [63:0]      o_accepted_count,
    output logic [63:0]      o_lost_count,
    output logic [63:0]      o_reordered_count,
    output logic [63:0]      o_bad_magic_count,
    output logic [63:0]      o_short_count,
    output logic [63:0]      o_next_expected
);

    psc_pkg::t_hs     q_stat;
    psc_pkg::t_qentry push_entry;
    psc_pkg::t_qentry pop_entry;
    logic             push;
    logic             pop;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = q_stat.ready;

    psc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .i_packet_length   (i_packet_length),
        .i_magic_word      (i_magic_word),
        .i_sequence_number (i_sequence_number),
        .i_q_ready         (q_stat.ready),
        .o_push            (push),
        .o_entry           (push_entry)
    );

    psc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_stat  (q_stat),
        .o_entry (pop_entry)
    );

    psc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_stat          (q_stat),
        .i_entry           (pop_entry),
        .o_pop             (pop),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_verdict         (o_verdict),
        .o_gap_amount      (o_gap_amount),
        .o_received_count  (o_received_count),
        .o_accepted_count  (o_accepted_count),
        .o_lost_count      (o_lost_count),
        .o_reordered_count (o_reordered_count),
        .o_bad_magic_count (o_bad_magic_count),
        .o_short_count     (o_short_count),
        .o_next_expected   (o_next_expected)
    );

endmodule
`default_nettype wire

FILE: src/psc_front.sv
`default_nettype none
module psc_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_valid,
    input  wire logic [63:0]     i_cfg_data,
    input  wire logic            i_in_valid,
    input  wire logic [15:0]     i_packet_length,
    input  wire logic [63:0]     i_magic_word,
    input  wire logic [63:0]     i_sequence_number,
    input  wire logic            i_q_ready,
    output logic                 o_push,
    output psc_pkg::t_qentry     o_entry
);

    logic [63:0] r_magic;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_magic <= psc_pkg::MAGIC_RESET;
        end else if (i_cfg_valid) begin
            r_magic <= i_cfg_data;
        end
    end

    always_comb begin
        o_push = i_in_valid & i_q_ready;
        o_entry.seq = i_sequence_number;
        if (i_packet_length < psc_pkg::MIN_HEADER_LEN) begin
            o_entry.cls = psc_pkg::C_SHORT;
        end else if (i_magic_word != r_magic) begin
            o_entry.cls = psc_pkg::C_BAD_MAGIC;
        end else begin
            o_entry.cls = psc_pkg::C_VALID;
        end
    end

endmodule
`default_nettype wire

FILE: src/psc_queue.sv
`default_nettype none
module psc_queue (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire psc_pkg::t_qentry i_entry,
    input  wire logic             i_pop,
    output psc_pkg::t_hs          o_stat,
    output psc_pkg::t_qentry      o_entry
);

    psc_pkg::t_qentry                r_mem [psc_pkg::QDEPTH];
    logic [psc_pkg::QPTR_W-1:0]      r_wr_ptr;
    logic [psc_pkg::QPTR_W-1:0]      r_rd_ptr;
    logic [psc_pkg::QCNT_W-1:0]      r_count;

    localparam logic [psc_pkg::QPTR_W-1:0] LAST = psc_pkg::QPTR_W'(psc_pkg::QDEPTH - 1);
    localparam logic [psc_pkg::QCNT_W-1:0] FULL = psc_pkg::QCNT_W'(psc_pkg::QDEPTH);

    always_comb begin
        o_stat.valid = (r_count != '0);
        o_stat.ready = (r_count != FULL);
        o_entry      = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: src/psc_back.sv
`default_nettype none
module psc_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire psc_pkg::t_hs     i_q_stat,
    input  wire psc_pkg::t_qentry i_entry,
    output logic                  o_pop,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [2:0]            o_verdict,
    output logic [63:0]           o_gap_amount,
    output logic [63:0]           o_received_count,
    output logic [63:0]           o_accepted_count,
    output logic [63:0]           o_lost_count,
    output logic [63:0]           o_reordered_count,
    output logic [63:0]           o_bad_magic_count,
    output logic [63:0]           o_short_count,
    output logic [63:0]           o_next_expected
);

    logic              r_out_valid;
    psc_pkg::t_verdict r_verdict;
    logic [63:0]       r_gap;
    logic              r_seen;
    logic [63:0]       r_expected;
    logic [63:0]       r_rx;
    logic [63:0]       r_ok;
    logic [63:0]       r_lost;
    logic [63:0]       r_ooo;
    logic [63:0]       r_bad;
    logic [63:0]       r_short;

    psc_pkg::t_verdict n_verdict;
    logic [63:0]       n_gap;
    logic [63:0]       exp_eff;
    logic [64:0]       diff;
    logic              seq_eq;
    logic              seq_gt;

    always_comb begin
        o_pop   = i_q_stat.valid & (~r_out_valid | i_out_ready);
        exp_eff = r_seen ? r_expected : i_entry.seq;
        diff    = {1'b0, i_entry.seq} - {1'b0, exp_eff};
        seq_eq  = (diff[63:0] == 64'd0);
        seq_gt  = ~diff[64] & ~seq_eq;
        n_gap   = 64'd0;
        case (i_entry.cls)
            psc_pkg::C_SHORT:     n_verdict = psc_pkg::V_TOO_SHORT;
            psc_pkg::C_BAD_MAGIC: n_verdict = psc_pkg::V_BAD_MAGIC;
            psc_pkg::C_VALID: begin
                if (seq_eq) begin
                    n_verdict = psc_pkg::V_IN_ORDER;
                end else if (seq_gt) begin
                    n_verdict = psc_pkg::V_GAP;
                    n_gap     = diff[63:0];
                end else begin
                    n_verdict = psc_pkg::V_OUT_OF_ORDER;
                end
            end
            default:              n_verdict = psc_pkg::V_TOO_SHORT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_verdict <= n_verdict;
            r_gap     <= n_gap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_seen      <= 1'b0;
            r_expected  <= '0;
            r_rx        <= '0;
            r_ok        <= '0;
            r_lost      <= '0;
            r_ooo       <= '0;
            r_bad       <= '0;
            r_short     <= '0;
        end else begin
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (o_pop) begin
                r_rx <= r_rx + 64'd1;
                case (n_verdict)
                    psc_pkg::V_IN_ORDER: begin
                        r_ok       <= r_ok + 64'd1;
                        r_expected <= i_entry.seq + 64'd1;
                        r_seen     <= 1'b1;
                    end
                    psc_pkg::V_GAP: begin
                        r_ok       <= r_ok + 64'd1;
                        r_lost     <= r_lost + n_gap;
                        r_expected <= i_entry.seq + 64'd1;
                        r_seen     <= 1'b1;
                    end
                    psc_pkg::V_OUT_OF_ORDER: r_ooo   <= r_ooo + 64'd1;
                    psc_pkg::V_BAD_MAGIC:    r_bad   <= r_bad + 64'd1;
                    psc_pkg::V_TOO_SHORT:    r_short <= r_short + 64'd1;
                    default:                 r_short <= r_short;
                endcase
            end
        end
    end

    always_comb begin
        o_out_valid       = r_out_valid;
        o_verdict         = r_verdict;
        o_gap_amount      = r_gap;
        o_received_count  = r_rx;
        o_accepted_count  = r_ok;
        o_lost_count      = r_lost;
        o_reordered_count = r_ooo;
        o_bad_magic_count = r_bad;
        o_short_count     = r_short;
        o_next_expected   = r_expected;
    end

endmodule
`default_nettype wire

FILE: src/psc_checker.sv
`default_nettype none
module psc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [2:0]  o_verdict,
    input wire logic [63:0] o_gap_amount,
    input wire logic [63:0] o_received_count
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

    a_gap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict != psc_pkg::V_GAP) |-> o_gap_amount == 64'd0)
        else $error("gap amount set without gap verdict");

    a_gap_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_verdict == psc_pkg::V_GAP) |-> o_gap_amount != 64'd0)
        else $error("gap verdict with zero gap amount");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_received_count))
        else $error("stalled result beat changed");

endmodule

bind packet_sequence_checker_core psc_checker u_psc_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_verdict        (o_verdict),
    .o_gap_amount     (o_gap_amount),
    .o_received_count (o_received_count)
);
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
`default_nettype none
module testbench;

    typedef struct {
        logic [2:0]  verdict;
        logic [63:0] gap_amount;
        logic [63:0] received;
        logic [63:0] accepted;
        logic [63:0] lost;
        logic [63:0] reordered;
        logic [63:0] magic_errs;
        logic [63:0] runts;
        logic [63:0] next_seq;
    } t_verdict_beat;

    class t_sequence_tally;
        logic [63:0]   cfg_magic = psc_pkg::MAGIC_RESET;
        logic [63:0]   exp_seq = '0;
        bit            seen_first = 1'b0;
        logic [63:0]   rx_cnt = '0;
        logic [63:0]   ok_cnt = '0;
        logic [63:0]   lost_cnt = '0;
        logic [63:0]   ooo_cnt = '0;
        logic [63:0]   bad_cnt = '0;
        logic [63:0]   short_cnt = '0;
        int unsigned   failures = 0;
        t_verdict_beat expected_beats[$];

        function int pending();
            return expected_beats.size();
        endfunction

        function void note_header(logic [15:0] len, logic [63:0] magic, logic [63:0] seq);
            t_verdict_beat      beat;
            psc_pkg::t_verdict  v;
            logic [63:0]        gap;
            gap = '0;
            rx_cnt++;
            if (len < psc_pkg::MIN_HEADER_LEN) begin
                short_cnt++;
                v = psc_pkg::V_TOO_SHORT;
            end else if (magic != cfg_magic) begin
                bad_cnt++;
                v = psc_pkg::V_BAD_MAGIC;
            end else begin
                if (!seen_first) begin
                    exp_seq = seq;
                    seen_first = 1'b1;
                end
                if (seq == exp_seq) begin
                    ok_cnt++;
                    exp_seq = exp_seq + 64'd1;
                    v = psc_pkg::V_IN_ORDER;
                end else if (seq > exp_seq) begin
                    gap = seq - exp_seq;
                    lost_cnt = lost_cnt + gap;
                    ok_cnt++;
                    exp_seq = seq + 64'd1;
                    v = psc_pkg::V_GAP;
                end else begin
                    ooo_cnt++;
                    v = psc_pkg::V_OUT_OF_ORDER;
                end
            end
            beat = '{v, gap, rx_cnt, ok_cnt, lost_cnt, ooo_cnt, bad_cnt, short_cnt, exp_seq};
            expected_beats.push_back(beat);
        endfunction

        function void mismatch(string field, logic [63:0] want, logic [63:0] got);
            failures++;
            if (failures <= 10)
                $display("mismatch on %s: expected %h, got %h", field, want, got);
        endfunction

        function void check_result(t_verdict_beat got);
            t_verdict_beat want;
            if (expected_beats.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("result beat with nothing expected, verdict %0d", got.verdict);
                return;
            end
            want = expected_beats.pop_front();
            if (got.verdict !== want.verdict)
                mismatch("verdict", 64'(want.verdict), 64'(got.verdict));
            if (got.gap_amount !== want.gap_amount)
                mismatch("gap_amount", want.gap_amount, got.gap_amount);
            if (got.received !== want.received)
                mismatch("received_count", want.received, got.received);
            if (got.accepted !== want.accepted)
                mismatch("accepted_count", want.accepted, got.accepted);
            if (got.lost !== want.lost)
                mismatch("lost_count", want.lost, got.lost);
            if (got.reordered !== want.reordered)
                mismatch("reordered_count", want.reordered, got.reordered);
            if (got.magic_errs !== want.magic_errs)
                mismatch("bad_magic_count", want.magic_errs, got.magic_errs);
            if (got.runts !== want.runts)
                mismatch("short_count", want.runts, got.runts);
            if (got.next_seq !== want.next_seq)
                mismatch("next_expected", want.next_seq, got.next_seq);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_packet_length;
    logic [63:0] i_magic_word;
    logic [63:0] i_sequence_number;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [2:0]  o_verdict;
    logic [63:0] o_gap_amount;
    logic [63:0] o_received_count;
    logic [63:0] o_accepted_count;
    logic [63:0] o_lost_count;
    logic [63:0] o_reordered_count;
    logic [63:0] o_bad_magic_count;
    logic [63:0] o_short_count;
    logic [63:0] o_next_expected;

    t_sequence_tally tally;
    t_verdict_beat   out_beat;
    logic [63:0]     magic_now;
    logic [63:0]     seq_cursor;
    bit              burst_mode;
    bit              hold_request;

    packet_sequence_checker_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_packet_length   (i_packet_length),
        .i_magic_word      (i_magic_word),
        .i_sequence_number (i_sequence_number),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_verdict         (o_verdict),
        .o_gap_amount      (o_gap_amount),
        .o_received_count  (o_received_count),
        .o_accepted_count  (o_accepted_count),
        .o_lost_count      (o_lost_count),
        .o_reordered_count (o_reordered_count),
        .o_bad_magic_count (o_bad_magic_count),
        .o_short_count     (o_short_count),
        .o_next_expected   (o_next_expected)
    );

    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready)
                tally.cfg_magic = i_cfg_data;
            if (i_in_valid && o_in_ready)
                tally.note_header(i_packet_length, i_magic_word, i_sequence_number);
            if (o_out_valid && i_out_ready) begin
                out_beat = '{o_verdict, o_gap_amount, o_received_count, o_accepted_count,
                             o_lost_count, o_reordered_count, o_bad_magic_count,
                             o_short_count, o_next_expected};
                tally.check_result(out_beat);
            end
        end
    end

    // receiver side, with one long hold-off on request
    initial begin
        int unsigned r;
        int          n;
        i_out_ready = 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (hold_request) begin
                i_out_ready = 1'b0;
                for (n = 0; n < 400; n++)
                    @(negedge i_clk);
                hold_request = 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    i_out_ready = 1'b1;
                    repeat ($urandom_range(60, 200)) @(negedge i_clk);
                end else if (r < 65) begin
                    i_out_ready = 1'b1;
                    repeat ($urandom_range(1, 6)) @(negedge i_clk);
                end else if (r < 92) begin
                    i_out_ready = 1'b0;
                    repeat ($urandom_range(1, 3)) @(negedge i_clk);
                end else begin
                    i_out_ready = 1'b0;
                    repeat ($urandom_range(10, 40)) @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("** packet_sequence_checker_core: FAILED **");
        $finish;
    end

    function int pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (burst_mode || r < 65)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // called at a falling edge; returns at a falling edge after the beat is taken
    task automatic offer_header(logic [15:0] len, logic [63:0] magic, logic [63:0] seq);
        int gap;
        i_packet_length = len;
        i_magic_word = magic;
        i_sequence_number = seq;
        i_in_valid = 1'b1;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        @(negedge i_clk);
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid = 1'b0;
        while (tally.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_magic(logic [63:0] value);
        i_cfg_data = value;
        i_cfg_valid = 1'b1;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        magic_now = value;
    endtask

    task automatic random_headers(int count);
        int unsigned r;
        logic [15:0] len;
        logic [63:0] mg;
        logic [63:0] sq;
        seq_cursor = tally.exp_seq;
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0)
                burst_mode = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            case ($urandom_range(0, 9))
                0:       len = psc_pkg::MIN_HEADER_LEN;
                1:       len = 16'hFFFF;
                default: len = 16'($urandom_range(16, 65535));
            endcase
            mg = magic_now;
            sq = seq_cursor;
            if (r < 60) begin
                sq = seq_cursor;
            end else if (r < 72) begin
                sq = seq_cursor + 64'($urandom_range(1, 20));
            end else if (r < 80) begin
                sq = seq_cursor - 64'($urandom_range(1, 20));
            end else if (r < 84) begin
                sq = {$urandom, $urandom};
            end else if (r < 92) begin
                len = 16'($urandom_range(0, 15));
                mg = ($urandom_range(0, 1) == 0) ? magic_now : {$urandom, $urandom};
                sq = {$urandom, $urandom};
            end else begin
                if ($urandom_range(0, 1) == 0)
                    mg = magic_now ^ (64'd1 << $urandom_range(0, 63));
                else
                    mg = {$urandom, $urandom};
                sq = {$urandom, $urandom};
            end
            if (len >= psc_pkg::MIN_HEADER_LEN && mg == magic_now && sq >= seq_cursor)
                seq_cursor = sq + 64'd1;
            offer_header(len, mg, sq);
        end
    endtask

    initial begin
        tally = new();
        magic_now = psc_pkg::MAGIC_RESET;
        burst_mode = 1'b0;
        hold_request = 1'b0;
        seq_cursor = '0;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_packet_length = '0;
        i_magic_word = '0;
        i_sequence_number = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // rejects before any valid packet, then order, gap, reorder and wrap
        offer_header(16'd0, psc_pkg::MAGIC_RESET, 64'd5);
        offer_header(16'd15, psc_pkg::MAGIC_RESET, '1);
        offer_header(16'd16, ~psc_pkg::MAGIC_RESET, 64'd7);
        offer_header(16'hFFFF, 64'd0, 64'd8);
        offer_header(16'd16, psc_pkg::MAGIC_RESET, 64'd100);
        offer_header(16'hFFFF, psc_pkg::MAGIC_RESET, 64'd101);
        offer_header(16'd17, psc_pkg::MAGIC_RESET, 64'd105);
        offer_header(16'd16, psc_pkg::MAGIC_RESET, 64'd50);
        offer_header(16'd16, psc_pkg::MAGIC_RESET, 64'd106);
        offer_header(16'd3, psc_pkg::MAGIC_RESET, 64'd107);
        offer_header(16'd16, ~psc_pkg::MAGIC_RESET, 64'd107);
        offer_header(16'd16, psc_pkg::MAGIC_RESET, 64'd107);
        offer_header(16'd16, psc_pkg::MAGIC_RESET, '1);
        offer_header(16'd16, psc_pkg::MAGIC_RESET, 64'd0);
        offer_header(16'd16, psc_pkg::MAGIC_RESET, 64'd0);
        offer_header(16'd16, psc_pkg::MAGIC_RESET, 64'h8000_0000_0000_0000);
        drain();

        write_magic('0);
        offer_header(16'd16, 64'd0, 64'h8000_0000_0000_0001);
        offer_header(16'd16, psc_pkg::MAGIC_RESET, 64'h8000_0000_0000_0002);
        offer_header(16'd16, 64'd0, 64'd5);
        drain();

        write_magic('1);
        offer_header(16'd16, '1, '1);
        offer_header(16'hFFFF, '1, 64'd0);
        offer_header(16'd15, '1, 64'd1);

        for (int p = 0; p < 4; p++) begin
            drain();
            case (p)
                0:       write_magic({$urandom, $urandom});
                1:       write_magic(psc_pkg::MAGIC_RESET);
                2:       write_magic({$urandom, $urandom});
                default: write_magic('1);
            endcase
            if (p == 0)
                hold_request = 1'b1;
            random_headers(470);
        end
        drain();

        if (tally.failures == 0)
            $display("** packet_sequence_checker_core: PASSED **");
        else
            $display("** packet_sequence_checker_core: FAILED **");
        $finish;
    end

endmodule
`default_nettype wire

FILE: filelist.f
src/psc_pkg.sv
src/psc_front.sv
src/psc_queue.sv
src/psc_back.sv
src/packet_sequence_checker_core.sv
src/psc_checker.sv
tb/sv/testbench.sv
